// ===== sv/bslpd_pkg.sv =====
// Shared types and constants for the button short/long press detector.
package bslpd_pkg;

  localparam int unsigned LEVEL_W     = 5;   // buttons carried on the ports
  localparam int unsigned STAMP_W     = 32;  // millisecond timestamp width
  localparam int unsigned THR_W       = 16;  // long-press threshold width
  localparam int unsigned IN_TDATA_W  = 40;  // now_ms + levels, byte padded
  localparam int unsigned OUT_TDATA_W = 16;  // short + long masks, byte padded

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000);

  // What one lane found on the current poll
  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } lane_evt_t;

endpackage

// ===== sv/bslpd_lane.sv =====
// One button lane: edge detect, press stamp, long-press flag.
module bslpd_lane
  import bslpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               cur_level,
  input  logic [STAMP_W-1:0] now_ms,
  input  logic [THR_W-1:0]   threshold,
  output lane_evt_t          evt
);

  logic               prev_r,  prev_nxt;
  logic               fired_r, fired_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [STAMP_W-1:0] elapsed;
  logic               reached;

  // wrapping difference
  assign elapsed = now_ms - stamp_r;
  assign reached = elapsed >= {{(STAMP_W-THR_W){1'b0}}, threshold};

  always_comb begin
    prev_nxt  = prev_r;
    fired_nxt = fired_r;
    stamp_nxt = stamp_r;
    evt       = '0;
    if (en) begin
      prev_nxt = cur_level;
      if (!cur_level && prev_r) begin
        stamp_nxt = now_ms;
        fired_nxt = 1'b0;
      end else if (cur_level && !prev_r) begin
        evt.short_hit = !fired_r;
        stamp_nxt     = '0;
      end else if (!cur_level && !prev_r) begin
        if (!fired_r && (stamp_r != '0) && reached) begin
          fired_nxt    = 1'b1;
          evt.long_hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b1;
      fired_r <= 1'b0;
      stamp_r <= '0;
    end else begin
      prev_r  <= prev_nxt;
      fired_r <= fired_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  a_long_latches: assert property (@(posedge clk) disable iff (!rst_n)
    evt.long_hit |=> fired_r)
    else $error("long press did not set the fired flag");

  a_long_armed: assert property (@(posedge clk) disable iff (!rst_n)
    evt.long_hit |-> (stamp_r != '0) && !prev_r && !cur_level)
    else $error("long press without an armed hold");

  a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    evt.short_hit |-> en && cur_level && !prev_r && !fired_r)
    else $error("short press outside a clean release");

endmodule

// ===== sv/bslpd_merge.sv =====
// Merges lane events into the result masks and holds the output register.
module bslpd_merge
  import bslpd_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  lane_evt_t [NUM_BUTTONS-1:0]       evt,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [LEVEL_W-1:0]                out_short,
  output logic [LEVEL_W-1:0]                out_long
);

  logic [LEVEL_W-1:0] short_vec, long_vec;
  logic               valid_r, valid_nxt;
  logic [LEVEL_W-1:0] short_r, long_r;

  for (genvar i = 0; i < LEVEL_W; i++) begin : g_pick
    if (i < NUM_BUTTONS) begin : g_lane
      assign short_vec[i] = evt[i].short_hit;
      assign long_vec[i]  = evt[i].long_hit;
    end else begin : g_none
      assign short_vec[i] = 1'b0;
      assign long_vec[i]  = 1'b0;
    end
  end

  // slot free when empty or draining this cycle
  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire)        valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      short_r <= short_vec;
      long_r  <= long_vec;
    end
  end

  assign out_valid = valid_r;
  assign out_short = short_r;
  assign out_long  = long_r;

  a_fire_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> in_ready)
    else $error("poll taken with the output slot occupied");

  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> valid_r && (short_r == $past(short_vec)) && (long_r == $past(long_vec)))
    else $error("result not loaded on poll transfer");

  a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((short_r & long_r) == '0))
    else $error("button reported short and long at once");

endmodule

// ===== sv/button_short_long_press_detector.sv =====
// Button short/long press detector: top level with config register and lanes.
//
// Each input transfer is one poll: a free-running millisecond timestamp and
// the active-low levels of the buttons. Every button has its own lane that
// remembers the last level, the press timestamp and whether a long press has
// fired for the current hold. A release without a long press gives a short
// press bit; a hold whose wrapping elapsed time reaches long_press_threshold
// gives one long press bit. A press seen at timestamp zero never arms a long
// press. No debouncing is done. Every poll yields exactly one result transfer.
// Throughput is one poll per clock unless the output stalls: all lanes update
// in the cycle of the transfer (one 32-bit subtract and compare each) and the
// result sits in a single output register that is refilled in the same cycle
// it is drained. The threshold is written through the cfg port, which is
// always ready, and should only be changed while idle.
module button_short_long_press_detector
  import bslpd_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // poll stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] now_ms, [36:32] levels, rest zero
  // event stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [4:0] short_press, [9:5] long_press, rest zero
  // threshold write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [THR_W-1:0]       cfg_data     // long_press_threshold, ms
);

  logic [THR_W-1:0]         thr_r, thr_nxt;
  logic                     in_fire;
  logic [STAMP_W-1:0]       now_ms;
  logic [LEVEL_W-1:0]       levels;
  lane_evt_t [NUM_BUTTONS-1:0] evt;
  logic [LEVEL_W-1:0]       short_press, long_press;

  assign now_ms  = in_tdata[STAMP_W-1:0];
  assign levels  = in_tdata[STAMP_W +: LEVEL_W];
  assign in_fire = in_tvalid && in_tready;

  // Threshold register; write always taken
  assign cfg_ready = 1'b1;
  assign thr_nxt   = (cfg_valid && cfg_ready) ? cfg_data : thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THR_RESET;
    else        thr_r <= thr_nxt;
  end

  // One lane per button; buttons past the port width read as pressed
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic lvl;
    if (i < LEVEL_W) begin : g_port
      assign lvl = levels[i];
    end else begin : g_extra
      assign lvl = 1'b0;
    end

    bslpd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (in_fire),
      .cur_level (lvl),
      .now_ms    (now_ms),
      .threshold (thr_r),
      .evt       (evt[i])
    );
  end

  bslpd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .evt       (evt),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_short (short_press),
    .out_long  (long_press)
  );

  assign out_tdata = {{(OUT_TDATA_W-2*LEVEL_W){1'b0}}, long_press, short_press};

endmodule

// ===== verif/button_short_long_press_detector_test.sv =====
// Self-checking testbench for the button short/long press detector.
module button_short_long_press_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bslpd_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 400000;  // many times the slowest legal run
  localparam int LONG_HOLD   = 400;     // receiver hold-off, in cycles
  localparam int SETTLE      = 4;       // extra wait after the last result
  localparam int PHASE_POLLS = 170;

  // Short and long masks carried by one result transfer
  typedef struct packed {
    logic [LEVEL_W-1:0] shorts;
    logic [LEVEL_W-1:0] longs;
  } press_masks_t;

  // Predicts the masks of every poll and checks result transfers in order.
  class press_ledger;
    logic [THR_W-1:0]   threshold;
    logic [LEVEL_W-1:0] last_level;
    logic [LEVEL_W-1:0] long_done;
    logic [STAMP_W-1:0] stamp [LEVEL_W];
    press_masks_t       expected_q [$];
    int                 mismatches;
    int                 checked;
    int                 short_bits;
    int                 long_bits;

    function void clear();
      threshold  = THR_RESET;
      last_level = '1;
      long_done  = '0;
      foreach (stamp[b]) stamp[b] = '0;
      expected_q.delete();
      mismatches = 0;
      checked    = 0;
      short_bits = 0;
      long_bits  = 0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] thr);
      threshold = thr;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // One accepted poll: every lane updates in parallel.
    function void note_poll(logic [STAMP_W-1:0] now, logic [LEVEL_W-1:0] lv);
      press_masks_t       m;
      logic [STAMP_W-1:0] elapsed;
      m = '0;
      for (int b = 0; b < LEVEL_W; b++) begin
        if (!lv[b] && last_level[b]) begin
          stamp[b]     = now;
          long_done[b] = 1'b0;
        end else if (lv[b] && !last_level[b]) begin
          if (!long_done[b]) m.shorts[b] = 1'b1;
          stamp[b] = '0;
        end else if (!lv[b] && !last_level[b]) begin
          elapsed = now - stamp[b];
          if (!long_done[b] && stamp[b] != '0 && elapsed >= STAMP_W'(threshold)) begin
            long_done[b] = 1'b1;
            m.longs[b]   = 1'b1;
          end
        end
      end
      last_level = lv;
      expected_q.push_back(m);
    endfunction

    function void check_event(logic [OUT_TDATA_W-1:0] data);
      press_masks_t want;
      logic [LEVEL_W-1:0] got_short;
      logic [LEVEL_W-1:0] got_long;
      got_short = data[LEVEL_W-1:0];
      got_long  = data[2*LEVEL_W-1:LEVEL_W];
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result transfer: short=%b long=%b",
                   $realtime, got_short, got_long);
        return;
      end
      want = expected_q.pop_front();
      short_bits += $countones(want.shorts);
      long_bits  += $countones(want.longs);
      if (got_short !== want.shorts || got_long !== want.longs) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d: short exp %b got %b, long exp %b got %b",
                   $realtime, checked, want.shorts, got_short, want.longs, got_long);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [31:0] now_ms, [36:32] levels, rest zero
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [4:0] short_press, [9:5] long_press, rest zero
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [THR_W-1:0]       cfg_data;    // long_press_threshold, ms

  press_ledger ledger;
  bit          idling;         // random idle bursts on both sides
  bit          rx_hold_req;    // asks the receiver for one long hold-off
  int          polls_sent;
  int          cycle_count;
  logic [STAMP_W-1:0] clock_ms;   // running timestamp for well-formed polls
  logic [LEVEL_W-1:0] held;       // current button levels

  button_short_long_press_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, ledger.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Result monitor: every output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_event(out_tdata);
  end

  // Receiver: ready in random stretches, random stall bursts, and one long
  // hold-off on request, counted here so the sender keeps pushing meanwhile.
  initial begin : receiver
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offer one poll and hold it until the transfer completes.
  task automatic send_poll(logic [STAMP_W-1:0] now, logic [LEVEL_W-1:0] lv);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({lv, now});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ledger.note_poll(now, lv);
    polls_sent++;
  endtask

  // Let every predicted result arrive, then wait out the SETTLE margin.
  task automatic drain_events();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Threshold write; only issued while the block is drained.
  task automatic write_threshold(logic [THR_W-1:0] thr);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ledger.set_threshold(thr);
  endtask

  // Random polls: mostly a steadily advancing clock with buttons that stay
  // put for a few polls (so holds reach the threshold), plus time-zero
  // polls and the odd random jump.
  task automatic press_traffic(int n_polls, int thr, int hold_at, int drain_at);
    int roll;
    int step_max;
    step_max = thr / 3 + 2;
    for (int k = 0; k < n_polls; k++) begin
      if (k == hold_at) rx_hold_req = 1'b1;
      if (k == drain_at) drain_events();
      roll = $urandom_range(0, 99);
      for (int b = 0; b < LEVEL_W; b++)
        if ($urandom_range(0, 5) == 0) held[b] = ~held[b];
      if (roll < 3) begin
        clock_ms = '0;                       // press at time zero never arms
      end else if (roll < 7) begin
        clock_ms = $urandom();
        held     = LEVEL_W'($urandom_range(0, 31));
      end else begin
        clock_ms = clock_ms + STAMP_W'($urandom_range(0, step_max));
      end
      send_poll(clock_ms, held);
    end
  endtask

  initial begin : stimulus
    int thr_plan [6];
    ledger = new;
    ledger.clear();
    idling      = 1'b1;
    rx_hold_req = 1'b0;
    polls_sent  = 0;
    cycle_count = 0;
    held        = '1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset threshold of 1000 ms
    send_poll(32'd5,          5'b11111);   // idle poll
    send_poll(32'd0,          5'b11110);   // press at time zero: not armed
    send_poll(32'd2000,       5'b11110);   // held long, still no long press
    send_poll(32'd2100,       5'b11111);   // release still gives a short press
    send_poll(32'd100,        5'b00000);   // all pressed together
    send_poll(32'd1099,       5'b00000);   // one ms short of the threshold
    send_poll(32'd1100,       5'b00000);   // exactly at threshold: all long
    send_poll(32'd5000,       5'b00000);   // long press fires only once
    send_poll(32'd5001,       5'b11111);   // release after long: no short
    send_poll(32'hFFFF_FF00,  5'b01010);   // press just before the wrap
    send_poll(32'hFFFF_FFFF,  5'b01010);
    send_poll(32'h0000_02E7,  5'b01010);   // wrapped elapsed 999
    send_poll(32'h0000_02E8,  5'b01011);   // one short, wrapped longs
    send_poll(32'h0000_0300,  5'b11111);
    send_poll(32'hAAAA_AAAA,  5'b10101);
    send_poll(32'h5555_5555,  5'b10101);   // huge wrapped elapsed time
    send_poll(32'hFFFF_FFFF,  5'b11111);
    send_poll(32'd10,         5'b00000);
    send_poll(32'd11,         5'b11111);   // quick tap on all buttons
    send_poll(32'hFFFF_FFFF,  5'b00000);   // press at the top of the range
    send_poll(32'h0000_03E6,  5'b00000);
    send_poll(32'h0000_03E7,  5'b00000);   // reaches 1000 across the wrap
    send_poll(32'h0000_0400,  5'b11111);
    drain_events();

    // Threshold plan: both extremes, random values, the reset value again
    thr_plan[0] = 1;
    thr_plan[1] = 65535;
    thr_plan[2] = $urandom_range(2, 64);
    thr_plan[3] = $urandom_range(1, 65535);
    thr_plan[4] = 1000;
    thr_plan[5] = $urandom_range(2, 300);

    for (int p = 0; p < 6; p++) begin
      write_threshold(THR_W'(thr_plan[p]));
      clock_ms = (p % 2 == 1) ? 32'hFFFF_FFFF - STAMP_W'($urandom_range(0, 3 * thr_plan[p]))
                              : STAMP_W'($urandom());
      if (p == 5) idling = 1'b0;           // closing stretch runs flat out
      press_traffic(PHASE_POLLS, thr_plan[p],
                    (p == 1) ? 40 : -1,    // long receiver hold-off
                    (p == 2) ? 80 : -1);   // sender waits for a full drain
      drain_events();
    end

    $display("covered %0d polls and %0d results: %0d short and %0d long press bits",
             polls_sent, ledger.checked, ledger.short_bits, ledger.long_bits);
    $display("thresholds used: 1000, %0d, %0d, %0d, %0d, %0d, %0d",
             thr_plan[0], thr_plan[1], thr_plan[2], thr_plan[3], thr_plan[4], thr_plan[5]);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               ledger.mismatches, ledger.pending());
      $display("status: fail");
    end
    $finish;
  end

endmodule
